[rtl/core/tps_pkg.sv]
// Shared constants and register map of the trapezoidal profile step block.
package tps_pkg;

  // Field widths (Q16.16)
  localparam int unsigned TimeW  = 32;
  localparam int unsigned PosW   = 32;
  localparam int unsigned LimW   = 31;
  localparam int unsigned MulW   = 32;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned ApbW   = 32;

  // Register reset values
  localparam logic [PosW-1:0] GoalRst = '0;
  localparam logic [LimW-1:0] AmaxRst = 31'd65536;
  localparam logic [LimW-1:0] VmaxRst = 31'd65536;

  // Register indexes (byte address / 4)
  localparam logic [1:0] RegGoal = 2'd0;
  localparam logic [1:0] RegAmax = 2'd1;
  localparam logic [1:0] RegVmax = 2'd2;

  // Cap on the |a|*dt*dt/2 term
  localparam logic [50:0] HalfCap = 51'h4_0000_0000_0000;

endpackage

[rtl/core/tps_mul.sv]
// Shared unsigned multiplier with registered product.
module tps_mul #(
  parameter int unsigned Width = tps_pkg::MulW
) (
  input  logic               clk_i,
  input  logic [Width-1:0]   a_i,
  input  logic [Width-1:0]   b_i,
  output logic [2*Width-1:0] p_o
);

  logic [2*Width-1:0] p_q;

  // one product per cycle, result registered
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

[rtl/core/trapezoidal_profile_step.sv]
// A sample passes the steps S_AV to S_POS before its result reaches the master side.
// One shared 32x32 multiplier is used six times per sample under an 8-step sequencer
// (s_axis_tready low meanwhile), so a new sample waits until the last one leaves S_POS.
// A finished result waits in the output register; the last step holds until it is taken.
// Reset (rst_ni low, async): time, position and velocity state clear to zero,
// goal 0, acceleration and velocity limits 1.0, no result pending.
module trapezoidal_profile_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  // config port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  // sample input
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [31:0]   s_axis_tdata,  // [31:0] sample_time
  // result output
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [127:0]  m_axis_tdata   // [31:0] out_time, [63:32] out_position,
                                       // [95:64] out_velocity,
                                       // [127:96] out_acceleration
);

  typedef enum logic [3:0] {
    S_IDLE, S_AV, S_AE, S_VV, S_DEC, S_HI, S_PV, S_CAP, S_POS
  } state_e;

  state_e state_q;

  // config registers
  logic signed [31:0] goal_q;
  logic [30:0]        amax_q;
  logic [30:0]        vmax_q;

  // kept state
  logic [31:0]        prev_time_q;
  logic signed [31:0] prev_pos_q;
  logic signed [31:0] prev_vel_q;

  // per-sample working registers
  logic [31:0]        time_q;
  logic [31:0]        adt_q;
  logic               dt_neg_q;
  logic [31:0]        emag_q;
  logic               err_neg_q;
  logic               err_zero_q;
  logic [46:0]        ad_q;
  logic [30:0]        vm_q;
  logic [64:0]        rhs_q;
  logic               acc_neg_q;
  logic signed [31:0] vel_q;
  logic [78:0]        hacc_q;
  logic signed [53:0] pvt_q;
  logic [50:0]        half_q;

  // output register
  logic               out_valid_q;
  logic [127:0]       out_data_q;

  // multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  // clamp a signed value to +-lim
  function automatic logic signed [31:0] clamp_vel(input logic signed [48:0] v,
                                                   input logic [30:0] lim);
    logic signed [48:0] l;
    begin
      l = $signed({18'b0, lim});
      if (v > l) clamp_vel = $signed({1'b0, lim});
      else if (v < -l) clamp_vel = -$signed({1'b0, lim});
      else clamp_vel = v[31:0];
    end
  endfunction

  // ---------------- config port ----------------
  logic cfg_wr;
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[3:2])
      tps_pkg::RegGoal: prdata = goal_q;
      tps_pkg::RegAmax: prdata = {1'b0, amax_q};
      tps_pkg::RegVmax: prdata = {1'b0, vmax_q};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_q <= tps_pkg::GoalRst;
      amax_q <= tps_pkg::AmaxRst;
      vmax_q <= tps_pkg::VmaxRst;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        tps_pkg::RegGoal: goal_q <= pwdata;
        tps_pkg::RegAmax: amax_q <= pwdata[30:0];
        tps_pkg::RegVmax: vmax_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // ---------------- datapath combinational ----------------
  logic               in_fire;
  logic               out_free;
  logic signed [32:0] dt;
  logic signed [32:0] err;
  logic               accel_neg;
  logic               pv_neg;
  logic [31:0]        pv_mag;
  logic signed [48:0] vterm;
  logic signed [48:0] vsum;
  logic signed [31:0] vclamp;
  logic               brake_cross;
  logic               heading;
  logic               acc_neg;
  logic [61:0]        half_full;
  logic signed [53:0] half_s;
  logic signed [53:0] pos_sum;
  logic signed [31:0] pos_sat;
  logic signed [31:0] acc_val;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign dt  = $signed({1'b0, s_axis_tdata}) - $signed({1'b0, prev_time_q});
  assign err = $signed({prev_pos_q[31], prev_pos_q}) - $signed({goal_q[31], goal_q});

  assign accel_neg = !err_neg_q;
  assign pv_neg    = prev_vel_q[31];
  assign pv_mag    = pv_neg ? 32'(-prev_vel_q) : 32'(prev_vel_q);

  // braking test: floor(v^2 / 2a) > |err|  <=>  v^2 >= 2a*|err| + 2a
  assign brake_cross = (amax_q != '0) && !err_zero_q && ({3'b0, prod[61:0]} >= rhs_q);
  assign heading = (err_neg_q && (prev_vel_q > 0)) ||
                   (!err_neg_q && !err_zero_q && (prev_vel_q < 0));
  assign acc_neg = accel_neg ^ (brake_cross & heading);

  // velocity update: S_AE uses the first product directly, S_DEC the stored one
  always_comb begin
    if (state_q == S_AE) begin
      vterm = $signed({2'b0, prod[62:16]});
      if (accel_neg ^ dt_neg_q) vterm = -vterm;
    end else begin
      vterm = $signed({2'b0, ad_q});
      if (acc_neg ^ dt_neg_q) vterm = -vterm;
    end
    vsum   = $signed({{17{prev_vel_q[31]}}, prev_vel_q}) + vterm;
    vclamp = clamp_vel(vsum, vmax_q);
  end

  // position sum and saturation
  assign half_full = hacc_q[78:17];
  assign half_s    = acc_neg_q ? -$signed({3'b0, half_q}) : $signed({3'b0, half_q});
  assign pos_sum   = $signed({{22{prev_pos_q[31]}}, prev_pos_q}) + pvt_q + half_s;
  always_comb begin
    if (pos_sum > 54'sd2147483647) pos_sat = 32'sh7FFF_FFFF;
    else if (pos_sum < -54'sd2147483648) pos_sat = 32'sh8000_0000;
    else pos_sat = pos_sum[31:0];
  end
  assign acc_val = acc_neg_q ? -$signed({1'b0, amax_q}) : $signed({1'b0, amax_q});

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_AV:  begin mul_a = {1'b0, amax_q}; mul_b = adt_q;          end
      S_AE:  begin mul_a = {1'b0, amax_q}; mul_b = emag_q;         end
      S_VV:  begin mul_a = {1'b0, vm_q};   mul_b = {1'b0, vm_q};   end
      S_DEC: begin mul_a = ad_q[31:0];     mul_b = adt_q;          end
      S_HI:  begin mul_a = {17'b0, ad_q[46:32]}; mul_b = adt_q;    end
      S_PV:  begin mul_a = pv_mag;         mul_b = adt_q;          end
      default: ;
    endcase
  end

  tps_mul #(
    .Width(tps_pkg::MulW)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prev_time_q <= '0;
      prev_pos_q  <= '0;
      prev_vel_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // S_POS either refills the register or finds it still unread
      if (out_valid_q && m_axis_tready && (state_q != S_POS)) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) state_q <= S_AV;
        end
        S_AV:  state_q <= S_AE;
        S_AE:  state_q <= S_VV;
        S_VV:  state_q <= S_DEC;
        S_DEC: state_q <= S_HI;
        S_HI:  state_q <= S_PV;
        S_PV:  state_q <= S_CAP;
        S_CAP: state_q <= S_POS;
        S_POS: begin
          if (out_free) begin
            prev_time_q <= time_q;
            prev_pos_q  <= pos_sat;
            prev_vel_q  <= vel_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // working registers (payload, no reset)
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          time_q     <= s_axis_tdata;
          dt_neg_q   <= dt[32];
          adt_q      <= dt[32] ? 32'(-dt) : dt[31:0];
          err_neg_q  <= err[32];
          err_zero_q <= (err == '0);
          emag_q     <= err[32] ? 32'(-err) : err[31:0];
        end
      end
      S_AE: begin
        ad_q <= prod[62:16];
        vm_q <= vclamp[31] ? 31'(-vclamp) : vclamp[30:0];
      end
      S_VV: begin
        rhs_q <= {1'b0, prod[62:0], 1'b0} + {33'b0, amax_q, 1'b0};
      end
      S_DEC: begin
        acc_neg_q <= acc_neg;
        vel_q     <= vclamp;
      end
      S_HI: begin
        hacc_q <= {15'b0, prod};
      end
      S_PV: begin
        hacc_q <= hacc_q + {prod[46:0], 32'b0};
      end
      S_CAP: begin
        pvt_q  <= (pv_neg ^ dt_neg_q) ? -$signed({6'b0, prod[63:16]})
                                      : $signed({6'b0, prod[63:16]});
        half_q <= (half_full > {11'b0, tps_pkg::HalfCap}) ? tps_pkg::HalfCap
                                                          : half_full[50:0];
      end
      S_POS: begin
        if (out_free) out_data_q <= {acc_val, vel_q, pos_sat, time_q};
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------- assertions ----------------
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("sample accepted while sequencer busy");

  a_result_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_POS))
    else $error("result raised outside final step");

  a_acc_is_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[127:96] == {1'b0, amax_q}) ||
                      (m_axis_tdata[127:96] == 32'(-{1'b0, amax_q})))
    else $error("acceleration not at +-limit");

  a_vel_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[95:64]) <= $signed({1'b0, vmax_q})) &&
                      ($signed(m_axis_tdata[95:64]) >= -$signed({1'b0, vmax_q})))
    else $error("velocity outside limit");

endmodule
